FILE: hw/rtl/horl_pkg.sv
// Shared types and constants for the hex object record loader.
// No dependencies; imported by every module of the loader.
package horl_pkg;

    // Width of the internal load address (wraps modulo 2**ADDR_WIDTH)
    localparam int ADDR_WIDTH = 16;

    // Output field widths
    localparam int KIND_W  = 2;
    localparam int WADDR_W = 16;
    localparam int BYTE_W  = 8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_E       = 8'h45;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified character
    typedef struct packed {
        logic       newline;
        logic       rec_t;
        logic       rec_e;
        logic       hex;
        logic [3:0] nibble;
    } tok_t;

    // Queue occupancy seen by the top level
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_status_t;

endpackage

FILE: hw/rtl/horl_front.sv
// Front end: takes characters and classifies them into tokens.
// Depends on horl_pkg; feeds horl_queue.
module horl_front
    import horl_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       q_full,
    output logic       push,
    output tok_t       token
);

    // Accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Character classification and hex decode
    always_comb
    begin
        token         = '0;
        token.newline = (char_code == CH_NEWLINE);
        token.rec_t   = (char_code == CH_T);
        token.rec_e   = (char_code == CH_E);
        if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            token.hex    = 1'b1;
            token.nibble = char_code[3:0];
        end
        else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                 (char_code >= 8'h61 && char_code <= 8'h66))
        begin
            token.hex    = 1'b1;
            token.nibble = char_code[3:0] + 4'd9;
        end
    end

endmodule

FILE: hw/rtl/horl_queue.sv
// Short token queue decoupling the front end from the record parser.
// Depends on horl_pkg.
module horl_queue
    import horl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tok_t      push_tok,
    input  logic      pop,
    output tok_t      head_tok,
    output q_status_t status
);

    tok_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

    assign head_tok     = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

FILE: hw/rtl/horl_back.sv
// Back end: record parser state machine and the result output register.
// Depends on horl_pkg; consumes tokens from horl_queue.
module horl_back
    import horl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  tok_t               tok,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  kind,
    output logic [WADDR_W-1:0] write_address,
    output logic [BYTE_W-1:0]  write_byte
);

    localparam logic [2:0] PH_LINE_START = 3'd0;
    localparam logic [2:0] PH_SKIP_LINE  = 3'd1;
    localparam logic [2:0] PH_SKIP_HIGH  = 3'd2;
    localparam logic [2:0] PH_ADDRESS    = 3'd3;
    localparam logic [2:0] PH_LENGTH     = 3'd4;
    localparam logic [2:0] PH_DATA_HIGH  = 3'd5;
    localparam logic [2:0] PH_DATA_LOW   = 3'd6;

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [ADDR_WIDTH-1:0] addr_next;
    logic [7:0]            left_reg;
    logic [7:0]            left_next;
    logic [3:0]            hi_reg;
    logic [3:0]            hi_next;
    logic                  finished_reg;
    logic                  finished_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [KIND_W-1:0]     kind_next;
    logic [WADDR_W-1:0]    waddr_reg;
    logic [WADDR_W-1:0]    waddr_next;
    logic [BYTE_W-1:0]     wbyte_reg;
    logic [BYTE_W-1:0]     wbyte_next;

    logic                  adv;
    logic                  emit;
    logic [ADDR_WIDTH+WADDR_W-1:0] addr_ext;

    // Output register frees up when empty or being taken
    assign adv      = !out_valid_reg || out_ready;
    assign pop      = tok_valid && adv;
    assign addr_ext = {{WADDR_W{1'b0}}, addr_reg};

    // Record parsing for one token
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        hi_next       = hi_reg;
        finished_next = finished_reg;
        emit          = 1'b0;
        kind_next     = kind_reg;
        waddr_next    = waddr_reg;
        wbyte_next    = wbyte_reg;

        if (pop && !finished_reg)
        begin
            if (tok.newline)
            begin
                phase_next = PH_LINE_START;
                cnt_next   = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_LINE_START:
                    begin
                        if (tok.rec_t)
                        begin
                            phase_next = PH_SKIP_HIGH;
                            cnt_next   = '0;
                            addr_next  = '0;
                            left_next  = '0;
                        end
                        else if (tok.rec_e)
                        begin
                            finished_next = 1'b1;
                            emit          = 1'b1;
                            kind_next     = KIND_END;
                            waddr_next    = '0;
                            wbyte_next    = '0;
                        end
                        else
                        begin
                            phase_next = PH_SKIP_LINE;
                        end
                    end
                    PH_SKIP_HIGH:
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        if (cnt_reg == 2'd1)
                        begin
                            phase_next = PH_ADDRESS;
                            cnt_next   = '0;
                        end
                    end
                    PH_ADDRESS, PH_LENGTH, PH_DATA_HIGH, PH_DATA_LOW:
                    begin
                        if (!tok.hex)
                        begin
                            // bad digit abandons the rest of the line
                            phase_next = PH_SKIP_LINE;
                            cnt_next   = '0;
                            emit       = 1'b1;
                            kind_next  = KIND_BAD;
                            waddr_next = '0;
                            wbyte_next = '0;
                        end
                        else if (phase_reg == PH_ADDRESS)
                        begin
                            addr_next = {addr_reg[ADDR_WIDTH-5:0], tok.nibble};
                            cnt_next  = cnt_reg + 2'd1;
                            if (cnt_reg == 2'd3)
                            begin
                                phase_next = PH_LENGTH;
                                cnt_next   = '0;
                            end
                        end
                        else if (phase_reg == PH_LENGTH)
                        begin
                            left_next = {left_reg[3:0], tok.nibble};
                            cnt_next  = cnt_reg + 2'd1;
                            if (cnt_reg == 2'd1)
                            begin
                                cnt_next   = '0;
                                phase_next = ({left_reg[3:0], tok.nibble} == 8'd0) ?
                                             PH_SKIP_LINE : PH_DATA_HIGH;
                            end
                        end
                        else if (phase_reg == PH_DATA_HIGH)
                        begin
                            hi_next    = tok.nibble;
                            phase_next = PH_DATA_LOW;
                        end
                        else
                        begin
                            // second digit of a pair: one memory write
                            emit       = 1'b1;
                            kind_next  = KIND_WRITE;
                            waddr_next = addr_ext[WADDR_W-1:0];
                            wbyte_next = {hi_reg, tok.nibble};
                            addr_next  = addr_reg + ADDR_WIDTH'(1);
                            left_next  = left_reg - 8'd1;
                            phase_next = (left_reg == 8'd1) ? PH_SKIP_LINE : PH_DATA_HIGH;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        // Output register valid
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = emit;
        end
    end

    // Parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE_START;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            left_reg      <= '0;
            hi_reg        <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            left_reg      <= left_next;
            hi_reg        <= hi_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= kind_next;
            waddr_reg <= waddr_next;
            wbyte_reg <= wbyte_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign write_address = waddr_reg;
    assign write_byte    = wbyte_reg;

endmodule

FILE: hw/rtl/hex_object_record_loader_core.sv
// Hex object record loader: one character per cycle unless out_ready stalls a result.
// A transferred character is written into the queue, then parsed from the queue head
// into the output register, from which its result is transferred.
// The parser consumes one token per cycle while the output register is free.
// Reset (rst_n, async, active low) returns to line start and clears the end flag.
// Depends on horl_pkg, horl_front, horl_queue, horl_back.
module hex_object_record_loader_core
    import horl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  kind,
    output logic [WADDR_W-1:0] write_address,
    output logic [BYTE_W-1:0]  write_byte
);

    logic      push;
    tok_t      front_tok;
    tok_t      head_tok;
    q_status_t q_stat;
    logic      pop;

    // Classify incoming characters
    horl_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .q_full    (q_stat.full),
        .push      (push),
        .token     (front_tok)
    );

    // Token queue
    horl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (front_tok),
        .pop      (pop),
        .head_tok (head_tok),
        .status   (q_stat)
    );

    // Record parser and result register
    horl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_valid     (!q_stat.empty),
        .tok           (head_tok),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .write_address (write_address),
        .write_byte    (write_byte)
    );

    // Once the end record is transferred, nothing more comes out
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && kind == KIND_END) |=> !out_valid)
        else $error("result after end record");

    // Only defined result kinds are presented
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_WRITE || kind == KIND_END || kind == KIND_BAD))
        else $error("undefined result kind");

    // A transferred character always lands in the queue
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_stat.empty)
        else $error("transferred character lost");

    // Occupancy never exceeds the queue depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

endmodule
